FILE: rtl/ssm_pkg.sv
// Shared types and constants for the sorted set merge block.
package ssm_pkg;

    // Default list depth and the upper end of its range
    localparam int LIST_DEPTH_DEF = 16;
    localparam int LIST_DEPTH_MAX = 32;

    // Count width covers every depth in the range, full list included
    localparam int CNT_W = $clog2(LIST_DEPTH_MAX + 1);

    // Result cap per job
    localparam int MAX_RESULTS = 32;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_UNION     = 3'd0;
    localparam logic [OP_W-1:0] OP_INTERSECT = 3'd1;
    localparam logic [OP_W-1:0] OP_DIFF      = 3'd2;
    localparam logic [OP_W-1:0] OP_SYMDIFF   = 3'd3;
    localparam logic [OP_W-1:0] OP_SUBSET    = 3'd4;
    localparam logic [OP_W-1:0] OP_STRICT    = 3'd5;

    // List memory write request from the front end
    typedef struct packed {
        logic                     we_a;
        logic                     we_b;
        logic [CNT_W-1:0]         addr;
        logic signed [DATA_W-1:0] data;
    } mem_wr_t;

    // One queued job: operation and the two list lengths
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] first_count;
        logic [CNT_W-1:0] second_count;
    } job_t;

endpackage

FILE: rtl/sorted_set_merge_operations.sv
// Top level of the sorted set merge block.
//
// Items load the two ascending lists at one item per cycle while busy is low; an
// element for a full list is dropped and an item for a list that has already
// ended is ignored. The item that ends the last open list raises busy, and busy
// stays high while the merge engine walks the lists: each pointer step is a
// registered list memory read, then a compare; the strict subset test can add a
// second pass over the first list. Results leave one per strobe cycle, each
// valid for exactly that cycle with no back-pressure, and the last carries
// final_result; an empty result is one item with valid_member low. At most
// MAX_RESULTS results are given per job. Busy falls as the final result appears.
// The operation register (cfg_data) is written whenever cfg_valid is high.
module sorted_set_merge_operations
    import ssm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic signed [DATA_W-1:0] element,
    input  logic                     list_end,
    input  logic                     no_element,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [OP_W-1:0]          cfg_data,
    output logic                     strobe,
    output logic signed [DATA_W-1:0] member,
    output logic                     valid_member,
    output logic                     truth,
    output logic                     final_result
);

    mem_wr_t                  wr;
    logic                     push, pop, not_empty, job_done;
    job_t                     push_job, pop_job;
    logic [CNT_W-1:0]         rd_addr_a, rd_addr_b;
    logic signed [DATA_W-1:0] rd_data_a, rd_data_b;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    ssm_front #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .element    (element),
        .list_end   (list_end),
        .no_element (no_element),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .wr         (wr),
        .push       (push),
        .push_job   (push_job),
        .job_done   (job_done)
    );

    ssm_list_mem #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_mem (
        .clk       (clk),
        .wr        (wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    ssm_job_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .pop_job   (pop_job),
        .not_empty (not_empty)
    );

    ssm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .pop_job      (pop_job),
        .pop          (pop),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .rd_data_a    (rd_data_a),
        .rd_data_b    (rd_data_b),
        .job_done     (job_done),
        .strobe       (strobe),
        .member       (member),
        .valid_member (valid_member),
        .truth        (truth),
        .final_result (final_result)
    );

endmodule

FILE: rtl/ssm_list_mem.sv
// Storage for the two lists: one write port, two registered read ports.
module ssm_list_mem
    import ssm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic                     clk,
    input  mem_wr_t                  wr,
    input  logic [CNT_W-1:0]         rd_addr_a,
    input  logic [CNT_W-1:0]         rd_addr_b,
    output logic signed [DATA_W-1:0] rd_data_a,
    output logic signed [DATA_W-1:0] rd_data_b
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic signed [DATA_W-1:0] first_mem  [LIST_DEPTH];
    logic signed [DATA_W-1:0] second_mem [LIST_DEPTH];

    // Writes from the loader
    always_ff @(posedge clk)
    begin
        if (wr.we_a)
        begin
            first_mem[wr.addr[IDX_W-1:0]] <= wr.data;
        end
        if (wr.we_b)
        begin
            second_mem[wr.addr[IDX_W-1:0]] <= wr.data;
        end
    end

    // Registered reads for the merge walk
    always_ff @(posedge clk)
    begin
        rd_data_a <= first_mem[rd_addr_a[IDX_W-1:0]];
        rd_data_b <= second_mem[rd_addr_b[IDX_W-1:0]];
    end

endmodule

FILE: rtl/ssm_front.sv
// Loader: takes items, fills the lists, holds the operation and issues jobs.
module ssm_front
    import ssm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic signed [DATA_W-1:0] element,
    input  logic                     list_end,
    input  logic                     no_element,
    input  logic                     cfg_valid,
    input  logic [OP_W-1:0]          cfg_data,
    output mem_wr_t                  wr,
    output logic                     push,
    output job_t                     push_job,
    input  logic                     job_done
);

    logic [CNT_W-1:0] first_count_reg,  first_count_next;
    logic [CNT_W-1:0] second_count_reg, second_count_next;
    logic             first_done_reg,   first_done_next;
    logic             second_done_reg,  second_done_next;
    logic             pending_reg,      pending_next;
    logic [OP_W-1:0]  operation_reg,    operation_next;

    logic             accept;
    logic             first_take, second_take;
    logic             first_store, second_store;
    logic [CNT_W-1:0] first_len, second_len;
    logic             first_end, second_end;
    logic             trigger;

    // Classify the item
    assign accept       = start && !pending_reg;
    assign first_take   = accept && !func && !first_done_reg;
    assign second_take  = accept && func && !second_done_reg;
    assign first_store  = first_take && !no_element
                          && (first_count_reg < CNT_W'(LIST_DEPTH));
    assign second_store = second_take && !no_element
                          && (second_count_reg < CNT_W'(LIST_DEPTH));

    assign first_len  = first_count_reg + CNT_W'(first_store);
    assign second_len = second_count_reg + CNT_W'(second_store);
    assign first_end  = first_done_reg | (first_take & list_end);
    assign second_end = second_done_reg | (second_take & list_end);
    assign trigger    = (first_take || second_take) && first_end && second_end;

    // Memory write
    assign wr.we_a = first_store;
    assign wr.we_b = second_store;
    assign wr.addr = func ? second_count_reg : first_count_reg;
    assign wr.data = element;

    // Job hand-off
    assign push              = trigger;
    assign push_job.op           = operation_reg;
    assign push_job.first_count  = first_len;
    assign push_job.second_count = second_len;

    assign busy = pending_reg;

    // Next state
    always_comb
    begin
        first_count_next  = first_len;
        second_count_next = second_len;
        first_done_next   = first_end;
        second_done_next  = second_end;
        pending_next      = pending_reg;
        operation_next    = operation_reg;
        if (trigger)
        begin
            first_count_next  = '0;
            second_count_next = '0;
            first_done_next   = 1'b0;
            second_done_next  = 1'b0;
            pending_next      = 1'b1;
        end
        else if (job_done)
        begin
            pending_next = 1'b0;
        end
        if (cfg_valid)
        begin
            operation_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            first_done_reg   <= 1'b0;
            second_done_reg  <= 1'b0;
            pending_reg      <= 1'b0;
            operation_reg    <= OP_UNION;
        end
        else
        begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            first_done_reg   <= first_done_next;
            second_done_reg  <= second_done_next;
            pending_reg      <= pending_next;
            operation_reg    <= operation_next;
        end
    end

endmodule

FILE: rtl/ssm_job_queue.sv
// Two-entry job queue between loader and merge engine.
module ssm_job_queue
    import ssm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic not_empty
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg,   fill_next;
    logic       do_push, do_pop;

    assign not_empty = (fill_reg != 2'd0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push && (fill_reg != 2'd2);
    assign do_pop    = pop && not_empty;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/ssm_back.sv
// Merge engine: two-pointer walk over the lists and result generation.
module ssm_back
    import ssm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     not_empty,
    input  job_t                     pop_job,
    output logic                     pop,
    output logic [CNT_W-1:0]         rd_addr_a,
    output logic [CNT_W-1:0]         rd_addr_b,
    input  logic signed [DATA_W-1:0] rd_data_a,
    input  logic signed [DATA_W-1:0] rd_data_b,
    output logic                     job_done,
    output logic                     strobe,
    output logic signed [DATA_W-1:0] member,
    output logic                     valid_member,
    output logic                     truth,
    output logic                     final_result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    localparam logic [1:0] K_MERGE  = 2'd0;
    localparam logic [1:0] K_SUBSET = 2'd1;
    localparam logic [1:0] K_EQUAL  = 2'd2;

    logic [1:0]               state_reg,  state_next;
    logic [1:0]               kind_reg,   kind_next;
    job_t                     job_reg,    job_next;
    logic [CNT_W-1:0]         i_reg,      i_next;
    logic [CNT_W-1:0]         j_reg,      j_next;
    logic [RES_W-1:0]         n_reg,      n_next;
    logic                     hold_valid_reg, hold_valid_next;
    logic signed [DATA_W-1:0] hold_reg,   hold_next;
    logic                     answer_reg, answer_next;

    logic                     strobe_reg, strobe_next;
    logic signed [DATA_W-1:0] member_reg, member_next;
    logic                     valid_reg,  valid_next;
    logic                     truth_reg,  truth_next;
    logic                     final_reg,  final_next;

    logic                     a_ok, b_ok, lt, gt;
    logic                     keep_a, keep_b, keep_both;
    logic                     emit;
    logic signed [DATA_W-1:0] emit_val;
    logic [RES_W-1:0]         n_inc;

    assign rd_addr_a = i_reg;
    assign rd_addr_b = j_reg;

    assign a_ok  = i_reg < job_reg.first_count;
    assign b_ok  = j_reg < job_reg.second_count;
    assign lt    = rd_data_a < rd_data_b;
    assign gt    = rd_data_a > rd_data_b;
    assign n_inc = n_reg + RES_W'(1);

    // What each set operation keeps
    always_comb
    begin
        keep_a    = 1'b0;
        keep_b    = 1'b0;
        keep_both = 1'b0;
        unique case (job_reg.op)
            OP_UNION:
            begin
                keep_a    = 1'b1;
                keep_b    = 1'b1;
                keep_both = 1'b1;
            end
            OP_INTERSECT: keep_both = 1'b1;
            OP_DIFF:      keep_a    = 1'b1;
            OP_SYMDIFF:
            begin
                keep_a = 1'b1;
                keep_b = 1'b1;
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        job_next        = job_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        answer_next     = answer_reg;
        strobe_next     = 1'b0;
        member_next     = member_reg;
        valid_next      = valid_reg;
        truth_next      = truth_reg;
        final_next      = final_reg;
        pop             = 1'b0;
        job_done        = 1'b0;
        emit            = 1'b0;
        emit_val        = rd_data_a;

        unique case (state_reg)
            S_IDLE:
            begin
                if (not_empty)
                begin
                    pop             = 1'b1;
                    job_next        = pop_job;
                    i_next          = '0;
                    j_next          = '0;
                    n_next          = '0;
                    hold_valid_next = 1'b0;
                    answer_next     = 1'b0;
                    if (pop_job.op == OP_SUBSET || pop_job.op == OP_STRICT)
                    begin
                        kind_next  = K_SUBSET;
                        state_next = S_FETCH;
                    end
                    else if (pop_job.op == OP_UNION || pop_job.op == OP_INTERSECT
                             || pop_job.op == OP_DIFF || pop_job.op == OP_SYMDIFF)
                    begin
                        kind_next  = K_MERGE;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        // unused codes give the empty result
                        kind_next  = K_MERGE;
                        state_next = S_FLUSH;
                    end
                end
            end

            S_FETCH:
            begin
                // read data for the current pointers lands this edge
                state_next = S_CMP;
            end

            S_CMP:
            begin
                state_next = S_FETCH;
                unique case (kind_reg)
                    K_MERGE:
                    begin
                        if (a_ok && b_ok)
                        begin
                            if (lt)
                            begin
                                emit   = keep_a;
                                i_next = i_reg + CNT_W'(1);
                            end
                            else if (gt)
                            begin
                                emit     = keep_b;
                                emit_val = rd_data_b;
                                j_next   = j_reg + CNT_W'(1);
                            end
                            else
                            begin
                                emit   = keep_both;
                                i_next = i_reg + CNT_W'(1);
                                j_next = j_reg + CNT_W'(1);
                            end
                        end
                        else if (a_ok)
                        begin
                            emit   = keep_a;
                            i_next = i_reg + CNT_W'(1);
                        end
                        else if (b_ok)
                        begin
                            emit     = keep_b;
                            emit_val = rd_data_b;
                            j_next   = j_reg + CNT_W'(1);
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end

                    K_SUBSET:
                    begin
                        if (a_ok && b_ok)
                        begin
                            if (lt)
                            begin
                                answer_next = 1'b0;
                                state_next  = S_FLUSH;
                            end
                            else if (gt)
                            begin
                                j_next = j_reg + CNT_W'(1);
                            end
                            else
                            begin
                                i_next = i_reg + CNT_W'(1);
                                j_next = j_reg + CNT_W'(1);
                            end
                        end
                        else if (i_reg != job_reg.first_count)
                        begin
                            answer_next = 1'b0;
                            state_next  = S_FLUSH;
                        end
                        else if (job_reg.op != OP_STRICT
                                 || job_reg.first_count != job_reg.second_count)
                        begin
                            answer_next = 1'b1;
                            state_next  = S_FLUSH;
                        end
                        else
                        begin
                            // same length: check the lists are not identical
                            kind_next = K_EQUAL;
                            i_next    = '0;
                            j_next    = '0;
                        end
                    end

                    K_EQUAL:
                    begin
                        if (a_ok)
                        begin
                            if (rd_data_a != rd_data_b)
                            begin
                                answer_next = 1'b1;
                                state_next  = S_FLUSH;
                            end
                            else
                            begin
                                i_next = i_reg + CNT_W'(1);
                                j_next = j_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            answer_next = 1'b0;
                            state_next  = S_FLUSH;
                        end
                    end

                    default:
                    begin
                        state_next = S_FLUSH;
                    end
                endcase

                // one result held back so the last can carry the final mark
                if (emit)
                begin
                    if (hold_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        member_next = hold_reg;
                        valid_next  = 1'b1;
                        truth_next  = 1'b0;
                        final_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_next       = emit_val;
                    n_next          = n_inc;
                    if (n_inc == RES_W'(MAX_RESULTS))
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end

            S_FLUSH:
            begin
                strobe_next = 1'b1;
                final_next  = 1'b1;
                if (hold_valid_reg)
                begin
                    member_next = hold_reg;
                    valid_next  = 1'b1;
                    truth_next  = 1'b0;
                end
                else
                begin
                    member_next = '0;
                    valid_next  = 1'b0;
                    truth_next  = answer_reg;
                end
                job_done   = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= K_MERGE;
            hold_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            hold_valid_reg <= hold_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        n_reg      <= n_next;
        hold_reg   <= hold_next;
        answer_reg <= answer_next;
        member_reg <= member_next;
        valid_reg  <= valid_next;
        truth_reg  <= truth_next;
        final_reg  <= final_next;
    end

    assign strobe       = strobe_reg;
    assign member       = member_reg;
    assign valid_member = valid_reg;
    assign truth        = truth_reg;
    assign final_result = final_reg;

endmodule

FILE: rtl/ssm_checker.sv
// Port-level checks for the sorted set merge block, bound to the top level.
module ssm_checker
    import ssm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic strobe,
    input logic valid_member,
    input logic truth,
    input logic final_result
);

    // A set element never carries a predicate answer
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && valid_member |-> !truth)
    else $error("ssm: element result with truth set");

    // Empty and predicate results are always the last of the job
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !valid_member |-> final_result)
    else $error("ssm: element-less result not marked final");

    // Results before the last one come out while the job is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !final_result |-> busy)
    else $error("ssm: intermediate result while idle");

    // Busy drops exactly when the final result appears
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && final_result)
    else $error("ssm: busy fell without final result");

    // Nothing follows the final result straight away
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && final_result |=> !strobe)
    else $error("ssm: result right after final");

endmodule

bind sorted_set_merge_operations ssm_checker u_ssm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .strobe       (strobe),
    .valid_member (valid_member),
    .truth        (truth),
    .final_result (final_result)
);

FILE: tb/sv/sorted_set_merge_operations_tb.sv
// Self-checking testbench for the sorted set merge block: directed rows, then random jobs.
module sorted_set_merge_operations_tb;
    import ssm_pkg::*;

    localparam int DEPTH         = LIST_DEPTH_DEF;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 120;
    localparam int PHASE_ITEMS   = 18;
    localparam int NUM_PHASES    = 9;
    localparam int MAX_REPORTS   = 10;

    // Operation codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // List selector values
    localparam logic FIRST  = 1'b0;
    localparam logic SECOND = 1'b1;

    localparam logic signed [DATA_W-1:0] ELEM_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] ELEM_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] element;
        logic                     list_end;
        logic                     no_element;
    } set_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] member;
        logic                     valid_member;
        logic                     truth;
        logic                     final_result;
    } member_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        set_item_t       item;
        logic            typed;
        member_t         want;
    } dir_row_t;

    typedef set_item_t item_q_t[$];

    localparam member_t NO_RES    = '0;
    localparam member_t EMPTY_RES = '{member: '0, valid_member: 1'b0, truth: 1'b0,
                                      final_result: 1'b1};
    localparam member_t TRUE_RES  = '{member: '0, valid_member: 1'b0, truth: 1'b1,
                                      final_result: 1'b1};
    localparam member_t FALSE_RES = EMPTY_RES;

    // Directed rows: operation, item, whether the result is typed in, typed result
    localparam dir_row_t DIRECTED_ROWS [26] = '{
        // both lists empty straight after reset
        '{OP_UNION,     '{FIRST,  32'sd0,   1'b1, 1'b1}, 1'b0, NO_RES},
        '{OP_UNION,     '{SECOND, 32'sd0,   1'b1, 1'b1}, 1'b1, EMPTY_RES},
        // value extremes
        '{OP_UNION,     '{FIRST,  ELEM_MIN, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{OP_UNION,     '{SECOND, ELEM_MAX, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{OP_INTERSECT, '{FIRST,  -32'sd1,  1'b0, 1'b0}, 1'b0, NO_RES},
        '{OP_INTERSECT, '{FIRST,  32'sd0,   1'b1, 1'b0}, 1'b0, NO_RES},
        '{OP_INTERSECT, '{SECOND, 32'sd0,   1'b1, 1'b0}, 1'b0, NO_RES},
        // difference of equal lists is empty
        '{OP_DIFF,      '{FIRST,  32'sd5,   1'b1, 1'b0}, 1'b0, NO_RES},
        '{OP_DIFF,      '{SECOND, 32'sd5,   1'b1, 1'b0}, 1'b1, EMPTY_RES},
        // stray item for an ended list, second list closed by an empty item
        '{OP_SYMDIFF,   '{FIRST,  32'sd1,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{OP_SYMDIFF,   '{FIRST,  32'sd3,   1'b1, 1'b0}, 1'b0, NO_RES},
        '{OP_SYMDIFF,   '{FIRST,  32'sd99,  1'b1, 1'b0}, 1'b0, NO_RES},
        '{OP_SYMDIFF,   '{SECOND, 32'sd2,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{OP_SYMDIFF,   '{SECOND, 32'sd3,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{OP_SYMDIFF,   '{SECOND, 32'sd0,   1'b1, 1'b1}, 1'b0, NO_RES},
        // empty set is a subset
        '{OP_SUBSET,    '{FIRST,  32'sd0,   1'b1, 1'b1}, 1'b0, NO_RES},
        '{OP_SUBSET,    '{SECOND, 32'sd7,   1'b1, 1'b0}, 1'b1, TRUE_RES},
        // identical lists are not a strict subset
        '{OP_STRICT,    '{FIRST,  32'sd7,   1'b1, 1'b0}, 1'b0, NO_RES},
        '{OP_STRICT,    '{SECOND, 32'sd7,   1'b1, 1'b0}, 1'b1, FALSE_RES},
        // unused codes give the empty result
        '{OP_SPARE_LO,  '{FIRST,  32'sd1,   1'b1, 1'b0}, 1'b0, NO_RES},
        '{OP_SPARE_LO,  '{SECOND, 32'sd2,   1'b1, 1'b0}, 1'b1, EMPTY_RES},
        '{OP_SPARE_HI,  '{SECOND, ELEM_MAX, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{OP_SPARE_HI,  '{FIRST,  ELEM_MIN, 1'b1, 1'b0}, 1'b1, EMPTY_RES},
        // unsorted first list
        '{OP_UNION,     '{FIRST,  32'sd3,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{OP_UNION,     '{FIRST,  32'sd1,   1'b1, 1'b0}, 1'b0, NO_RES},
        '{OP_UNION,     '{SECOND, 32'sd2,   1'b1, 1'b0}, 1'b0, NO_RES}
    };

    localparam logic [OP_W-1:0] PHASE_OPS [NUM_PHASES] = '{
        OP_UNION, OP_SYMDIFF, OP_INTERSECT, OP_SUBSET, OP_DIFF,
        OP_STRICT, OP_SPARE_LO, OP_UNION, OP_SPARE_HI
    };
    localparam int IDLE_PCT [3] = '{0, 77, 37};

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     func;
    logic signed [DATA_W-1:0] element;
    logic                     list_end;
    logic                     no_element;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [OP_W-1:0]          cfg_data;
    logic                     strobe;
    logic signed [DATA_W-1:0] member;
    logic                     valid_member;
    logic                     truth;
    logic                     final_result;

    // Predictor state
    logic signed [DATA_W-1:0] first_vals  [DEPTH];
    logic signed [DATA_W-1:0] second_vals [DEPTH];
    int                       first_len;
    int                       second_len;
    bit                       first_closed;
    bit                       second_closed;
    logic [OP_W-1:0]          cur_operation;

    member_t job_results[$];
    member_t expected_members[$];
    int      mismatch_count;
    int      stall_cycles;
    int      phase_items;

    sorted_set_merge_operations dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .element      (element),
        .list_end     (list_end),
        .no_element   (no_element),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .member       (member),
        .valid_member (valid_member),
        .truth        (truth),
        .final_result (final_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result item into the job's list, capped per job
    function automatic void add_member(input logic signed [DATA_W-1:0] v, input logic valid,
                                       input logic t);
        if (job_results.size() < MAX_RESULTS)
            job_results.push_back('{v, valid, t, 1'b0});
    endfunction

    // Two-pointer walk over both lists
    function automatic void walk_merge(input bit keep_a, input bit keep_b, input bit keep_both);
        int i;
        int j;
        i = 0;
        j = 0;
        while (i < first_len && j < second_len)
        begin
            if (first_vals[i] < second_vals[j])
            begin
                if (keep_a)
                    add_member(first_vals[i], 1'b1, 1'b0);
                i++;
            end
            else if (first_vals[i] > second_vals[j])
            begin
                if (keep_b)
                    add_member(second_vals[j], 1'b1, 1'b0);
                j++;
            end
            else
            begin
                if (keep_both)
                    add_member(first_vals[i], 1'b1, 1'b0);
                i++;
                j++;
            end
        end
        for (; i < first_len; i++)
            if (keep_a)
                add_member(first_vals[i], 1'b1, 1'b0);
        for (; j < second_len; j++)
            if (keep_b)
                add_member(second_vals[j], 1'b1, 1'b0);
    endfunction

    function automatic bit first_is_subset();
        int i;
        int j;
        i = 0;
        j = 0;
        while (i < first_len && j < second_len)
        begin
            if (first_vals[i] < second_vals[j])
                return 1'b0;
            if (first_vals[i] == second_vals[j])
                i++;
            j++;
        end
        return i == first_len;
    endfunction

    function automatic bit lists_match();
        if (first_len != second_len)
            return 1'b0;
        for (int k = 0; k < first_len; k++)
            if (first_vals[k] != second_vals[k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Load one item; when both lists have ended, fill job_results with the job's output
    function automatic void predict_set_op(input set_item_t it);
        member_t tail;
        job_results.delete();
        if (it.func == FIRST)
        begin
            if (first_closed)
                return;
            if (!it.no_element && first_len < DEPTH)
            begin
                first_vals[first_len] = it.element;
                first_len++;
            end
            if (it.list_end)
                first_closed = 1'b1;
        end
        else
        begin
            if (second_closed)
                return;
            if (!it.no_element && second_len < DEPTH)
            begin
                second_vals[second_len] = it.element;
                second_len++;
            end
            if (it.list_end)
                second_closed = 1'b1;
        end
        if (!(first_closed && second_closed))
            return;

        case (cur_operation)
            OP_UNION:     walk_merge(1'b1, 1'b1, 1'b1);
            OP_INTERSECT: walk_merge(1'b0, 1'b0, 1'b1);
            OP_DIFF:      walk_merge(1'b1, 1'b0, 1'b0);
            OP_SYMDIFF:   walk_merge(1'b1, 1'b1, 1'b0);
            OP_SUBSET:    add_member('0, 1'b0, first_is_subset());
            OP_STRICT:    add_member('0, 1'b0, first_is_subset() && !lists_match());
            default:      ;
        endcase
        if (job_results.size() == 0)
            add_member('0, 1'b0, 1'b0);
        tail = job_results.pop_back();
        tail.final_result = 1'b1;
        job_results.push_back(tail);

        first_len     = 0;
        second_len    = 0;
        first_closed  = 1'b0;
        second_closed = 1'b0;
    endfunction

    // Drop start and let the block drain before touching the register
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_members.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_operation(input logic [OP_W-1:0] op);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= op;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid     <= 1'b0;
        cur_operation = op;
    endtask

    // Offer one item after random idle cycles, then book its expected results
    task automatic send_item(input set_item_t it, input int idle_pct, input bit typed,
                             input member_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        func       <= it.func;
        element    <= it.element;
        list_end   <= it.list_end;
        no_element <= it.no_element;
        do @(posedge clk); while (busy);
        predict_set_op(it);
        if (typed)
            expected_members.push_back(want);
        else
            foreach (job_results[k])
                expected_members.push_back(job_results[k]);
        phase_items++;
    endtask

    function automatic int pick_value(input int base);
        case ($urandom_range(9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(3))
                    0: return ELEM_MIN;
                    1: return ELEM_MAX;
                    2: return -1;
                    default: return 0;
                endcase
            end
            default: return base + $urandom_range(24);
        endcase
    endfunction

    function automatic int list_size();
        if ($urandom_range(9) == 0)
            return $urandom_range(DEPTH + 2, DEPTH - 4);
        return $urandom_range(6);
    endfunction

    // Items of one list, ascending unless scrambled, with odd empty items mixed in
    function automatic item_q_t build_list(input logic side, input int n, input int base,
                                           input bit scrambled);
        int        vals[$];
        item_q_t   items;
        set_item_t it;
        for (int k = 0; k < n; k++)
            vals.push_back(pick_value(base));
        if (scrambled)
            vals.shuffle();
        else
            vals.sort();
        foreach (vals[k])
        begin
            if ($urandom_range(19) == 0)
                items.push_back('{side, $urandom, 1'b0, 1'b1});
            items.push_back('{side, vals[k], 1'b0, 1'b0});
        end
        if (n == 0 || $urandom_range(9) == 0)
        begin
            items.push_back('{side, $urandom, 1'b1, 1'b1});
        end
        else
        begin
            it = items.pop_back();
            it.list_end = 1'b1;
            items.push_back(it);
        end
        return items;
    endfunction

    // One job: both lists interleaved, strays sent to a list that has already ended
    task automatic run_job(input int idle_pct, input bit fill_lists);
        item_q_t   pend_first;
        item_q_t   pend_second;
        set_item_t it;
        int        base;
        bit        scrambled;
        base      = ($urandom_range(7) == 0) ? int'($urandom) : int'($urandom_range(200)) - 100;
        scrambled = ($urandom_range(9) == 0);
        pend_first  = build_list(FIRST, fill_lists ? DEPTH + 1 : list_size(), base, scrambled);
        pend_second = build_list(SECOND,
                                 fill_lists ? $urandom_range(DEPTH + 2, DEPTH - 1) : list_size(),
                                 base, scrambled);
        // now and then hold off until every result is in
        if ($urandom_range(5) == 0)
            wait_idle();
        while (pend_first.size() != 0 || pend_second.size() != 0)
        begin
            if (pend_second.size() == 0 || (pend_first.size() != 0 && $urandom_range(1) == 1))
                it = pend_first.pop_front();
            else
                it = pend_second.pop_front();
            send_item(it, idle_pct, 1'b0, NO_RES);
            if ((pend_first.size() == 0) != (pend_second.size() == 0) && $urandom_range(4) == 0)
            begin
                it = '{(pend_first.size() == 0) ? FIRST : SECOND, $urandom,
                       1'($urandom_range(1)), 1'($urandom_range(1))};
                send_item(it, idle_pct, 1'b0, NO_RES);
            end
        end
    endtask

    task automatic check_member(input member_t got);
        member_t want;
        if (expected_members.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected result: member %0d valid_member %b truth %b final %b",
                         got.member, got.valid_member, got.truth, got.final_result);
        end
        else
        begin
            want = expected_members.pop_front();
            if (got.member !== want.member || got.valid_member !== want.valid_member
                || got.truth !== want.truth || got.final_result !== want.final_result)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("mismatch m/v/t/f: expected %0d/%b/%b/%b got %0d/%b/%b/%b",
                             want.member, want.valid_member, want.truth, want.final_result,
                             got.member, got.valid_member, got.truth, got.final_result);
            end
        end
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            check_member('{member, valid_member, truth, final_result});
    end

    // Cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        func       <= 1'b0;
        element    <= '0;
        list_end   <= 1'b0;
        no_element <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;

        first_len      = 0;
        second_len     = 0;
        first_closed   = 1'b0;
        second_closed  = 1'b0;
        cur_operation  = OP_UNION;
        phase_items    = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows
        set_operation(OP_UNION);
        foreach (DIRECTED_ROWS[r])
        begin
            if (DIRECTED_ROWS[r].op != cur_operation)
                set_operation(DIRECTED_ROWS[r].op);
            send_item(DIRECTED_ROWS[r].item, 0, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end

        // random jobs, one operation and one idle pattern per phase
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_operation(PHASE_OPS[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                run_job(IDLE_PCT[p % 3], (p % 4 == 0) && (phase_items == 0));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_members.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/ssm_pkg.sv
rtl/ssm_list_mem.sv
rtl/ssm_front.sv
rtl/ssm_job_queue.sv
rtl/ssm_back.sv
rtl/sorted_set_merge_operations.sv
rtl/ssm_checker.sv
tb/sv/sorted_set_merge_operations_tb.sv
